[rtl/core/ahd_pkg.sv]
// ----------------------------------------------------------------------------
// ahd_pkg
// Shared types, register indexes and constants of the alpha hole dilation
// block.
// ----------------------------------------------------------------------------
package ahd_pkg;

	localparam int CHAN_W      = 8;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_ALPHA   = 2'd2;

	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CALC
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic emit;
	} ahd_cmd_t;

	typedef struct packed {
		logic have;
		logic out_free;
	} ahd_status_t;

	// ceil(2^16 / cnt); exact floor division for sums up to 9 * 255
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		unique case (cnt)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/ahd_stream_if.sv]
// ----------------------------------------------------------------------------
// ahd_stream_if
// Valid/ready stream interfaces for incoming pixels and result pixels.
// ----------------------------------------------------------------------------
interface ahd_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic [7:0] in_alpha;
	logic       pad_item;

	modport source (output valid, in_red, in_green, in_blue, in_alpha, pad_item,
		input ready);
	modport sink (input valid, in_red, in_green, in_blue, in_alpha, pad_item,
		output ready);
endinterface

interface ahd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       frame_last;

	modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_last,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, frame_last,
		output ready);
endinterface

[rtl/core/ahd_ctrl.sv]
// ----------------------------------------------------------------------------
// ahd_ctrl
// Sequencer: take one pixel, load the line buffers and window, then, when the
// item yields a result, divide and hand it to the output register.
// ----------------------------------------------------------------------------
module ahd_ctrl import ahd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ahd_status_t status,
	output ahd_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = status.have ? ST_CALC : ST_IDLE;
			end
			ST_CALC: begin
				// hold until the output register can take the result
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.load   = (state_q == ST_LOAD);
		cmd.emit   = (state_q == ST_CALC) && status.out_free;
	end

endmodule

[rtl/core/ahd_datapath.sv]
// ----------------------------------------------------------------------------
// ahd_datapath
// Configuration registers, frame position, line buffers, 3x3 window, masked
// neighbour sums, reciprocal divide and the output register.
// ----------------------------------------------------------------------------
module ahd_datapath import ahd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [CHAN_W-1:0]    in_red,
	input  logic [CHAN_W-1:0]    in_green,
	input  logic [CHAN_W-1:0]    in_blue,
	input  logic [CHAN_W-1:0]    in_alpha,
	input  logic                 pad_item,
	input  ahd_cmd_t             cmd,
	output ahd_status_t          status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAN_W-1:0]    out_red,
	output logic [CHAN_W-1:0]    out_green,
	output logic [CHAN_W-1:0]    out_blue,
	output logic [CHAN_W-1:0]    out_alpha,
	output logic                 frame_last
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int PW = SUM_W + RECIP_W;

	localparam logic [WW-1:0] MAX_W   = WW'(MAX_WIDTH);
	localparam logic [HW-1:0] MAX_H   = HW'(MAX_HEIGHT);
	localparam logic [WW-1:0] W_RESET = WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
	localparam logic [HW-1:0] H_RESET = HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);

	// configuration
	logic [WW-1:0]     width_q;
	logic [HW-1:0]     height_q;
	logic [CHAN_W-1:0] pass_q;
	logic [WW-1:0]     width_new;
	logic [HW-1:0]     height_new;
	logic [31:0]       cfg_ext;
	logic              restart;

	assign cfg_ext = 32'(cfg_data);
	assign restart = cfg_we && (cfg_index == REG_IMAGE_WIDTH ||
		cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_PASS_ALPHA);

	always_comb begin
		priority if (cfg_ext == 32'd0) width_new = WW'(1);
		else if (cfg_ext > 32'(MAX_WIDTH)) width_new = MAX_W;
		else width_new = WW'(cfg_ext);

		priority if (cfg_ext == 32'd0) height_new = HW'(1);
		else if (cfg_ext > 32'(MAX_HEIGHT)) height_new = MAX_H;
		else height_new = HW'(cfg_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_RESET;
			height_q <= H_RESET;
			pass_q   <= 8'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_IMAGE_WIDTH)  width_q  <= width_new;
			if (cfg_index == REG_IMAGE_HEIGHT) height_q <= height_new;
			if (cfg_index == REG_PASS_ALPHA)   pass_q   <= cfg_data[CHAN_W-1:0];
		end
	end

	// frame position and location of the result pixel
	logic [XW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] rp;
	logic [XW-1:0] cp;
	logic          have;
	logic          last;
	logic          wrap;
	logic [XW-1:0] w_last;
	logic [RW-1:0] h_last;

	assign w_last = XW'(width_q - WW'(1));
	assign h_last = RW'(height_q) - RW'(1);
	assign wrap   = (WW'(col_q) + WW'(1)) >= width_q;

	always_comb begin
		rp   = '0;
		cp   = '0;
		have = 1'b0;
		if (col_q != '0) begin
			if (row_q != '0) begin
				rp   = row_q - RW'(1);
				cp   = col_q - XW'(1);
				have = rp < RW'(height_q);
			end
		end else if (row_q >= RW'(2)) begin
			rp   = row_q - RW'(2);
			cp   = w_last;
			have = rp < RW'(height_q);
		end
		last = have && (rp == h_last) && (cp == w_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			priority if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	logic [XW-1:0] x_q;
	pixel_t        pix_q;
	logic          have_q;
	logic          last_q;
	logic [2:0]    row_ok_q;
	logic [2:0]    col_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.accept) begin
			have_q <= have;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q      <= col_q;
			pix_q    <= pad_item ? '0 : {in_alpha, in_blue, in_green, in_red};
			last_q   <= last;
			row_ok_q <= {rp != h_last, 1'b1, rp != '0};
			col_ok_q <= {cp != w_last, 1'b1, cp != '0};
		end
	end

	// line buffers: two rows up and one row up at the current column
	pixel_t upper_mem [MAX_WIDTH];
	pixel_t middle_mem [MAX_WIDTH];
	pixel_t top_rd_q;
	pixel_t mid_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			top_rd_q <= upper_mem[col_q];
			mid_rd_q <= middle_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			upper_mem[x_q]  <= mid_rd_q;
			middle_mem[x_q] <= pix_q;
		end
	end

	// 3x3 window, shifted left with the new column entering on the right
	pixel_t win_q [9];
	pixel_t win_next [9];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_next[i*3]     = win_q[i*3+1];
			win_next[i*3 + 1] = win_q[i*3+2];
		end
		win_next[2] = top_rd_q;
		win_next[5] = mid_rd_q;
		win_next[8] = pix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) win_q[k] <= '0;
		end else if (cmd.load) begin
			for (int k = 0; k < 9; k++) win_q[k] <= win_next[k];
		end
	end

	// masked sums of qualifying neighbours
	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;
	logic [CNT_W-1:0] cnt;
	logic [SUM_W-1:0] sum_r_q;
	logic [SUM_W-1:0] sum_g_q;
	logic [SUM_W-1:0] sum_b_q;
	logic [CNT_W-1:0] cnt_q;
	pixel_t           center_q;

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		cnt   = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (row_ok_q[i] && col_ok_q[j] && (win_next[i*3+j].alpha > pass_q)) begin
					sum_r = sum_r + SUM_W'(win_next[i*3+j].red);
					sum_g = sum_g + SUM_W'(win_next[i*3+j].green);
					sum_b = sum_b + SUM_W'(win_next[i*3+j].blue);
					cnt   = cnt + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_r_q  <= sum_r;
			sum_g_q  <= sum_g;
			sum_b_q  <= sum_b;
			cnt_q    <= cnt;
			center_q <= win_next[4];
		end
	end

	// divide by the count through its reciprocal
	logic [RECIP_W-1:0] rcp;
	logic [PW-1:0]      prod_r;
	logic [PW-1:0]      prod_g;
	logic [PW-1:0]      prod_b;
	logic               fill;
	pixel_t             result;

	always_comb begin
		rcp    = recip(cnt_q);
		prod_r = PW'(sum_r_q) * PW'(rcp);
		prod_g = PW'(sum_g_q) * PW'(rcp);
		prod_b = PW'(sum_b_q) * PW'(rcp);
		fill   = (center_q.alpha == '0) && (cnt_q != '0);
		if (fill) begin
			result.red   = prod_r[RECIP_SHIFT +: CHAN_W];
			result.green = prod_g[RECIP_SHIFT +: CHAN_W];
			result.blue  = prod_b[RECIP_SHIFT +: CHAN_W];
			result.alpha = pass_q;
		end else begin
			result = center_q;
		end
	end

	// output register
	logic   out_valid_q;
	pixel_t out_pix_q;
	logic   out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pix_q  <= result;
			out_last_q <= last_q;
		end
	end

	assign status.have     = have_q;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_red    = out_pix_q.red;
	assign out_green  = out_pix_q.green;
	assign out_blue   = out_pix_q.blue;
	assign out_alpha  = out_pix_q.alpha;
	assign frame_last = out_last_q;

endmodule

[rtl/core/alpha_hole_dilation_3x3.sv]
// ----------------------------------------------------------------------------
// alpha_hole_dilation_3x3
// One dilation pass that fills zero-alpha pixels from their opaque neighbours.
// ----------------------------------------------------------------------------
// Pixels enter on the pixels channel in raster order; results leave on the
// results channel, each lagging its input by image_width + 1 items. After the
// last pixel of a frame, image_width + 1 items with pad_item set flush it out;
// frame_last marks the final result pixel.
// Each item passes the states idle (the registered line-buffer read) and load
// (update of the window and the masked sums), and, when it yields a result, calc
// (the reciprocal divide into the output register); a new pixel is taken only in idle.
// The output register lets the next pixel be transferred while a result still
// waits; if the receiver stalls, the block holds in the divide step until the
// output register frees, and the pixel channel stalls in turn.
// Configuration writes on cfg_we/cfg_index/cfg_data restart the frame and are
// to be made while the block is idle; the block does not enforce this. Reset
// clears the position counters, the window and the output valid, loads width and
// height min(1024, MAX_*) and pass alpha 1; the line buffers are not cleared.
module alpha_hole_dilation_3x3 import ahd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	ahd_pixel_if.sink            pixels,
	ahd_result_if.source         results
);

	ahd_cmd_t    cmd;
	ahd_status_t status;
	logic        in_ready;

	ahd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ahd_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_red     (pixels.in_red),
		.in_green   (pixels.in_green),
		.in_blue    (pixels.in_blue),
		.in_alpha   (pixels.in_alpha),
		.pad_item   (pixels.pad_item),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.out_red    (results.out_red),
		.out_green  (results.out_green),
		.out_blue   (results.out_blue),
		.out_alpha  (results.out_alpha),
		.frame_last (results.frame_last)
	);

	assign pixels.ready = in_ready;

endmodule

[tb/sv/alpha_hole_dilation_3x3_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_hole_dilation_3x3_tb
// Streams RGBA frames through the dilation block and compares every result
// pixel with a cycle-free prediction of the fill. A short hand-made set of
// frames covers edges, pads and pass values; random frames of varied size,
// with broken frames and random stalls on both channels, follow.
// ----------------------------------------------------------------------------
module alpha_hole_dilation_3x3_tb import ahd_pkg::*; ();

	localparam int MAX_SIDE = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		pixel_t pix;
		logic   last;
	} result_pixel_t;

	class fill_scoreboard;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [7:0]       pass_reg;
		pixel_t           upper_line[MAX_SIDE];
		pixel_t           middle_line[MAX_SIDE];
		pixel_t           window[9];
		int unsigned      col;
		int unsigned      row;
		result_pixel_t    expected_pixels[$];
		int unsigned      errors;

		function new();
			width_reg = 11'd1024;
			height_reg = 11'd1024;
			pass_reg = 8'd1;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			foreach (window[i])
				window[i] = '0;
			col = 0;
			row = 0;
			errors = 0;
		endfunction

		static function int unsigned clamp_size(input logic [CFG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_SIDE)
				return MAX_SIDE;
			return 32'(v);
		endfunction

		function void note_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_W-1:0] val);
			case (idx)
				REG_IMAGE_WIDTH: width_reg = val;
				REG_IMAGE_HEIGHT: height_reg = val;
				REG_PASS_ALPHA: pass_reg = val[7:0];
				default: return;
			endcase
			col = 0;
			row = 0;
		endfunction

		function void take_pixel(input pixel_t p, input logic pad);
			int unsigned w, h, x, r, rp, cp, cnt, sum_r, sum_g, sum_b;
			pixel_t pix, top, mid, nb;
			logic have;
			result_pixel_t res;
			w = clamp_size(width_reg);
			h = clamp_size(height_reg);
			x = col;
			r = row;
			if (x >= w)
				x = 0;
			pix = pad ? pixel_t'('0) : p;
			top = upper_line[x];
			mid = middle_line[x];
			upper_line[x] = mid;
			middle_line[x] = pix;
			for (int i = 0; i < 3; i++) begin
				window[i*3] = window[i*3+1];
				window[i*3+1] = window[i*3+2];
			end
			window[2] = top;
			window[5] = mid;
			window[8] = pix;

			// the result sits one row and one pixel behind the item just taken
			have = 1'b0;
			rp = 0;
			cp = 0;
			if (x >= 1) begin
				if (r >= 1) begin
					rp = r - 1;
					cp = x - 1;
					have = rp < h;
				end
			end else if (r >= 2) begin
				rp = r - 2;
				cp = w - 1;
				have = rp < h;
			end
			if (x + 1 >= w) begin
				col = 0;
				row = r + 1;
			end else begin
				col = x + 1;
			end
			if (!have)
				return;

			res.pix = window[4];
			res.last = (rp == h - 1) && (cp == w - 1);
			if (window[4].alpha == 0) begin
				sum_r = 0;
				sum_g = 0;
				sum_b = 0;
				cnt = 0;
				for (int i = 0; i < 3; i++) begin
					if ((i == 0 && rp == 0) || (i == 2 && rp + 1 >= h))
						continue;
					for (int j = 0; j < 3; j++) begin
						if ((j == 0 && cp == 0) || (j == 2 && cp + 1 >= w))
							continue;
						nb = window[i*3+j];
						if (nb.alpha > pass_reg) begin
							sum_r += 32'(nb.red);
							sum_g += 32'(nb.green);
							sum_b += 32'(nb.blue);
							cnt++;
						end
					end
				end
				if (cnt > 0) begin
					res.pix.red = 8'(sum_r / cnt);
					res.pix.green = 8'(sum_g / cnt);
					res.pix.blue = 8'(sum_b / cnt);
					res.pix.alpha = pass_reg;
				end
			end
			expected_pixels.push_back(res);
			if (res.last) begin
				col = 0;
				row = 0;
			end
		endfunction

		function void compare_field(input string name, input int unsigned want,
				input int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(input result_pixel_t got);
			result_pixel_t want;
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected result pixel: expected none, actual %h last %b",
					$time, got.pix, got.last);
				errors++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("out_red", 32'(want.pix.red), 32'(got.pix.red));
			compare_field("out_green", 32'(want.pix.green), 32'(got.pix.green));
			compare_field("out_blue", 32'(want.pix.blue), 32'(got.pix.blue));
			compare_field("out_alpha", 32'(want.pix.alpha), 32'(got.pix.alpha));
			compare_field("frame_last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ahd_pixel_if  pixels();
	ahd_result_if results();

	fill_scoreboard sb;

	int unsigned      src_idle_pct;
	int unsigned      sink_idle_pct;
	logic [CFG_W-1:0] cur_w;
	logic [CFG_W-1:0] cur_h;
	logic [7:0]       cur_pass;
	logic             frame_open;

	alpha_hole_dilation_3x3 #(
		.MAX_WIDTH(MAX_SIDE),
		.MAX_HEIGHT(MAX_SIDE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixels(pixels),
		.results(results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		results.ready = 1'b0;
		forever begin
			@(negedge clk);
			results.ready <= arst_n && ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pixels.valid && pixels.ready)
				sb.take_pixel({pixels.in_alpha, pixels.in_blue, pixels.in_green,
					pixels.in_red}, pixels.pad_item);
			if (results.valid && results.ready)
				sb.check_result({results.out_alpha, results.out_blue, results.out_green,
					results.out_red, results.frame_last});
		end
	end

	function automatic pixel_t mk_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		return {a, b, g, r};
	endfunction

	function automatic logic [7:0] rand_channel();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return 8'($urandom_range(0, 255));
	endfunction

	// favor holes and alphas right at the pass value
	function automatic pixel_t rand_pixel();
		logic [7:0] a;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: a = 8'd0;
			4: a = cur_pass;
			5: a = 8'(cur_pass + 8'd1);
			6: a = 8'd255;
			default: a = 8'($urandom_range(0, 255));
		endcase
		return mk_pixel(rand_channel(), rand_channel(), rand_channel(), a);
	endfunction

	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return '0;
			7, 8: return CFG_W'($urandom_range(7, 16));
			default: return CFG_W'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [7:0] pick_pass();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 3));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input pixel_t p, input logic pad);
		while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			pixels.valid <= 1'b0;
			@(negedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.in_red <= p.red;
		pixels.in_green <= p.green;
		pixels.in_blue <= p.blue;
		pixels.in_alpha <= p.alpha;
		pixels.pad_item <= pad;
		do
			@(posedge clk);
		while (!pixels.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		int unsigned waited;
		pixels.valid <= 1'b0;
		waited = 0;
		while (sb.expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (sb.expected_pixels.size() != 0) begin
			$display("%0t: %0d expected result pixels never arrived", $time,
				sb.expected_pixels.size());
			sb.errors++;
			sb.expected_pixels.delete();
		end
		// let an item that yields no result leave the pipeline
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.note_register(idx, val);
		@(negedge clk);
	endtask

	// which: bit 0 width, bit 1 height, bit 2 pass alpha, bit 3 spare index
	task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [7:0] pa, input logic [3:0] which);
		logic [2:0] junk;
		if (which == 0)
			return;
		wait_idle();
		junk = 3'($urandom_range(0, 7));
		if (which[0]) begin
			write_reg(REG_IMAGE_WIDTH, w);
			cur_w = w;
		end
		if (which[1]) begin
			write_reg(REG_IMAGE_HEIGHT, h);
			cur_h = h;
		end
		if (which[2]) begin
			write_reg(REG_PASS_ALPHA, {junk, pa});
			cur_pass = pa;
		end
		if (which[3])
			write_reg(REG_SPARE, {junk, 8'hA5});
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input int unsigned w_eff, input int unsigned h_eff,
			input int unsigned cut);
		int unsigned n;
		logic pad;
		n = w_eff * h_eff;
		for (int unsigned k = 0; k < cut; k++) begin
			if (k < n)
				pad = ($urandom_range(0, 19) == 0);
			else
				pad = ($urandom_range(0, 9) != 0);
			send_item(rand_pixel(), pad);
		end
	endtask

	task automatic run_directed();
		// 3x3 frame, any nonzero alpha counts
		configure(11'd3, 11'd3, 8'd0, 4'b0111);
		send_item(mk_pixel(8'd255, 8'd255, 8'd255, 8'd255), 1'b0);
		send_item(mk_pixel(8'd10, 8'd20, 8'd30, 8'd0), 1'b0);
		send_item(mk_pixel(8'd0, 8'd0, 8'd0, 8'd1), 1'b0);
		send_item(mk_pixel(8'd1, 8'd2, 8'd3, 8'd0), 1'b0);
		// pad inside the frame: a black hole in the center
		send_item(mk_pixel(8'd77, 8'd88, 8'd99, 8'd200), 1'b1);
		send_item(mk_pixel(8'd200, 8'd100, 8'd50, 8'd128), 1'b0);
		// corner hole with no opaque neighbour
		send_item(mk_pixel(8'd7, 8'd7, 8'd7, 8'd0), 1'b0);
		send_item(mk_pixel(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
		send_item(mk_pixel(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
		send_item('0, 1'b1);
		// pixel during flush acts as a pad
		send_item(mk_pixel(8'd123, 8'd45, 8'd67, 8'd255), 1'b0);
		send_item('0, 1'b1);
		send_item('0, 1'b1);

		// zero width acts as one; nothing can exceed the top pass value
		configure(11'd0, 11'd1, 8'd255, 4'b1111);
		send_item(mk_pixel(8'd9, 8'd8, 8'd7, 8'd0), 1'b0);
		send_item('0, 1'b1);
		send_item('0, 1'b1);

		configure(11'd2, 11'd2, 8'd254, 4'b0111);
		send_item(mk_pixel(8'd40, 8'd50, 8'd60, 8'd255), 1'b0);
		send_item(mk_pixel(8'd1, 8'd1, 8'd1, 8'd254), 1'b0);
		send_item(mk_pixel(8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
		send_item(mk_pixel(8'd250, 8'd250, 8'd250, 8'd0), 1'b0);
		send_item('0, 1'b1);
		send_item('0, 1'b1);
		send_item('0, 1'b1);
	endtask

	// big: 0 none, 1 a cut-short widest row first, 2 a cut-short tallest column first
	task automatic run_random_phase(input int unsigned budget, input int unsigned big);
		int unsigned sent, w_eff, h_eff, total, cut;
		logic [CFG_W-1:0] w, h;
		logic [7:0] pa;
		logic [3:0] which;
		logic broken, first;
		sent = 0;
		first = 1'b1;
		while (sent < budget) begin
			w = pick_size();
			h = pick_size();
			pa = pick_pass();
			if ($urandom_range(0, 3) == 0)
				which = 4'd0;
			else if ($urandom_range(0, 2) == 0)
				which = 4'($urandom_range(1, 7));
			else
				which = 4'd7;
			broken = ($urandom_range(0, 11) == 0);
			if (first && big != 0) begin
				w = (big == 1) ? 11'd2047 : 11'd1;
				h = (big == 1) ? 11'd1 : 11'd2047;
				which = 4'd7;
				broken = 1'b1;
			end else if (broken && $urandom_range(0, 2) == 0) begin
				w = 11'd1024;
				h = 11'd1024;
				which = 4'd7;
			end
			// a broken frame needs a register write to restart
			if (frame_open && which == 0)
				which = 4'd7;
			configure(w, h, pa, which);
			w_eff = fill_scoreboard::clamp_size(cur_w);
			h_eff = fill_scoreboard::clamp_size(cur_h);
			total = w_eff * h_eff + w_eff + 1;
			if (broken)
				cut = $urandom_range(1, (total > 200) ? 40 : total - 1);
			else
				cut = total;
			send_frame(w_eff, h_eff, cut);
			sent += cut;
			first = 1'b0;
			frame_open = broken;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixels.valid = 1'b0;
		pixels.in_red = '0;
		pixels.in_green = '0;
		pixels.in_blue = '0;
		pixels.in_alpha = '0;
		pixels.pad_item = 1'b0;
		src_idle_pct = 17;
		sink_idle_pct = 71;
		cur_w = 11'd1024;
		cur_h = 11'd1024;
		cur_pass = 8'd1;
		frame_open = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		run_random_phase(450, 1);
		src_idle_pct = 71;
		sink_idle_pct = 17;
		run_random_phase(450, 2);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_random_phase(450, 0);
		wait_idle();

		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#10ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
rtl/core/ahd_pkg.sv
rtl/core/ahd_stream_if.sv
rtl/core/ahd_ctrl.sv
rtl/core/ahd_datapath.sv
rtl/core/alpha_hole_dilation_3x3.sv
tb/sv/alpha_hole_dilation_3x3_tb.sv
